// ===== src/dbu_pkg.sv =====
package dbu_pkg;

    localparam int MAX_THREADS = 64;
    localparam int MAX_ROUNDS  = 6;

    localparam int THR_W  = $clog2(MAX_THREADS);
    localparam int CNT_W  = 7;                       // num_threads register width
    localparam int RND_W  = $clog2(MAX_ROUNDS + 1);
    localparam int FLAG_W = 2 * MAX_ROUNDS;
    localparam int BIT_W  = $clog2(FLAG_W);
    localparam int STAT_W = 2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_WAIT  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_WRONG = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic             sense;
        logic             parity;
        logic [RND_W-1:0] rnd;
        logic             inb;
    } t_thr_state;

    localparam t_thr_state THR_RESET = '{sense: 1'b1, parity: 1'b0, rnd: '0, inb: 1'b0};

    typedef struct packed {
        logic             en;
        logic [THR_W-1:0] addr;
        t_thr_state       data;
    } t_thr_wr;

    typedef struct packed {
        logic             en;
        logic [THR_W-1:0] addr;
        logic [BIT_W-1:0] bit_idx;
        logic             value;
    } t_flag_wr;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RND_W-1:0]  rnd;
    } t_result;

    function automatic logic [CNT_W-1:0] eff_threads(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] e;
        e = n;
        if (n == '0) e = CNT_W'(1);
        if (n > CNT_W'(MAX_THREADS)) e = CNT_W'(MAX_THREADS);
        return e;
    endfunction

    // smallest r with 2^r >= n, capped
    function automatic logic [RND_W-1:0] eff_rounds(input logic [CNT_W-1:0] n);
        logic [RND_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if (((CNT_W+1)'(1) << i) < {1'b0, n}) r = RND_W'(i + 1);
        end
        return r;
    endfunction

endpackage

// ===== src/dissemination_barrier_unit.sv =====
// Channel   | Direction | Handshake               | Carries
// ----------+-----------+-------------------------+-----------------------------
// item in   | input     | i_valid / o_stall       | i_op, i_thread
// result    | output    | o_valid / i_stall       | o_status, o_round
// config    | input     | i_cfg_valid / o_cfg_ready | i_num_threads
//
// Each request first reads the thread state and flag memories, then works out the step
// and writes back. The registered read of the memories sets that split into read and
// write-back; one request is in flight at a time.
// Reset (synchronous, i_rst_n low) and every config write clear the valid bits of
// both memories at once, so entries read as their reset values; no clearing pass.
// A pending config write holds the request input so the two never land together.
// A finished result waits in the output register while the next request is read;
// a stalled output only holds the write-back cycle when a second result is ready.
module dissemination_barrier_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [dbu_pkg::THR_W-1:0]   i_thread,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dbu_pkg::STAT_W-1:0]  o_status,
    output logic [dbu_pkg::RND_W-1:0]   o_round,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dbu_pkg::CNT_W-1:0]   i_num_threads
);
    import dbu_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             r_state, n_state;
    logic             r_op;
    logic [THR_W-1:0] r_thread;
    logic [CNT_W-1:0] r_n_eff;
    logic [RND_W-1:0] r_rounds;
    logic             r_out_valid, n_out_valid;
    t_result          r_res;

    logic              in_acc;
    logic              cfg_acc;
    logic              load;
    t_thr_state        st_rd;
    logic [FLAG_W-1:0] flags_rd;
    t_thr_wr           thr_wr, step_thr_wr;
    t_flag_wr          flag_wr, step_flag_wr;
    t_result           step_res;

    assign in_acc      = i_valid && !o_stall;
    // hold requests off while one is in flight or a config write is offered
    assign o_stall     = (r_state == S_EXEC) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    // write back only when the output register can take the result
    assign load        = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    // gate the write ports so a held step writes exactly once
    always_comb begin
        thr_wr     = step_thr_wr;
        thr_wr.en  = step_thr_wr.en && load;
        flag_wr    = step_flag_wr;
        flag_wr.en = step_flag_wr.en && load;
    end

    dbu_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_acc),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_thread),
        .o_rd_data (st_rd),
        .i_wr      (thr_wr)
    );

    dbu_flag_mem u_flag_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_acc),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_thread),
        .o_rd_data (flags_rd),
        .i_wr      (flag_wr)
    );

    dbu_step u_step (
        .i_op      (r_op),
        .i_thread  (r_thread),
        .i_n_eff   (r_n_eff),
        .i_rounds  (r_rounds),
        .i_st      (st_rd),
        .i_flags   (flags_rd),
        .o_thr_wr  (step_thr_wr),
        .o_flag_wr (step_flag_wr),
        .o_res     (step_res)
    );

    // advance from read to write-back, hold while the result has nowhere to go
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n_eff     <= CNT_W'(MAX_THREADS);
            r_rounds    <= eff_rounds(CNT_W'(MAX_THREADS));
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            // keep the sanitised thread count and its round count ready to use
            if (cfg_acc) begin
                r_n_eff  <= eff_threads(i_num_threads);
                r_rounds <= eff_rounds(eff_threads(i_num_threads));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_op;
            r_thread <= i_thread;
        end
        if (load) begin
            r_res <= step_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_res.status;
    assign o_round  = r_res.rnd;

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !r_out_valid) |=> (r_state == S_IDLE))
        else $error("write-back stalled with an empty output register");

    a_partner_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flag_wr.en |-> (flag_wr.addr != r_thread))
        else $error("flag write aimed at the acting thread");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (thr_wr.en || flag_wr.en) |-> ({1'b0, r_thread} < r_n_eff))
        else $error("memory write for an out-of-range thread");

    a_release_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_REL || o_status == STAT_RANGE)) |-> (o_round == '0))
        else $error("released or rejected request reports a non-zero round");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && step_res.status == STAT_WAIT) |-> (step_res.rnd < r_rounds))
        else $error("waiting thread reports a round beyond the round count");

endmodule

// ===== src/dbu_state_mem.sv =====
module dbu_state_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_rd_en,
    input  logic [dbu_pkg::THR_W-1:0]  i_rd_addr,
    output dbu_pkg::t_thr_state        o_rd_data,
    input  dbu_pkg::t_thr_wr           i_wr
);
    import dbu_pkg::*;

    t_thr_state             mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_vld;
    t_thr_state             r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // unwritten entries read as their reset value
    assign o_rd_data = r_rd_vld ? r_rd_data : THR_RESET;

endmodule

// ===== src/dbu_flag_mem.sv =====
module dbu_flag_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_rd_en,
    input  logic [dbu_pkg::THR_W-1:0]  i_rd_addr,
    output logic [dbu_pkg::FLAG_W-1:0] o_rd_data,
    input  dbu_pkg::t_flag_wr          i_wr
);
    import dbu_pkg::*;

    logic [FLAG_W-1:0]      mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_vld;
    logic [FLAG_W-1:0]      r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // single-bit write; a first write to an entry lays down the whole word
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (r_vld[i_wr.addr]) begin
                mem[i_wr.addr][i_wr.bit_idx] <= i_wr.value;
            end else begin
                mem[i_wr.addr] <= FLAG_W'(i_wr.value) << i_wr.bit_idx;
            end
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== src/dbu_step.sv =====
module dbu_step (
    input  logic                       i_op,
    input  logic [dbu_pkg::THR_W-1:0]  i_thread,
    input  logic [dbu_pkg::CNT_W-1:0]  i_n_eff,
    input  logic [dbu_pkg::RND_W-1:0]  i_rounds,
    input  dbu_pkg::t_thr_state        i_st,
    input  logic [dbu_pkg::FLAG_W-1:0] i_flags,
    output dbu_pkg::t_thr_wr           o_thr_wr,
    output dbu_pkg::t_flag_wr          o_flag_wr,
    output dbu_pkg::t_result           o_res
);
    import dbu_pkg::*;

    logic [CNT_W:0]   sum;
    logic [CNT_W:0]   partner;
    logic [RND_W-1:0] r_sig;
    logic [RND_W-1:0] r_inc;
    logic [BIT_W-1:0] own_bit;
    logic             signal;
    logic             do_rel;
    t_thr_state       rel_st;

    assign rel_st = '{sense: i_st.sense ^ i_st.parity, parity: ~i_st.parity,
                      rnd: '0, inb: 1'b0};
    assign own_bit = i_st.parity ? BIT_W'(MAX_ROUNDS) + BIT_W'(i_st.rnd) : BIT_W'(i_st.rnd);
    assign r_inc   = i_st.rnd + RND_W'(1);

    // partner = thread + 2^round, wrapped once
    always_comb begin
        sum     = (CNT_W+1)'(i_thread) + ((CNT_W+1)'(1) << r_sig);
        partner = (sum >= (CNT_W+1)'(i_n_eff)) ? sum - (CNT_W+1)'(i_n_eff) : sum;
    end

    always_comb begin
        o_thr_wr       = '0;
        o_thr_wr.addr  = i_thread;
        o_thr_wr.data  = i_st;
        o_res.status   = STAT_WAIT;
        o_res.rnd      = i_st.rnd;
        signal         = 1'b0;
        do_rel         = 1'b0;
        r_sig          = '0;

        if ({1'b0, i_thread} >= i_n_eff) begin
            o_res.status = STAT_RANGE;
            o_res.rnd    = '0;
        end else if (i_op == OP_ARRIVE) begin
            if (i_st.inb) begin
                o_res.status = STAT_WRONG;
            end else if (i_rounds == '0) begin
                do_rel = 1'b1;
            end else begin
                o_thr_wr.en       = 1'b1;
                o_thr_wr.data.inb = 1'b1;
                o_thr_wr.data.rnd = '0;
                o_res.rnd         = '0;
                signal            = 1'b1;
            end
        end else begin
            if (!i_st.inb) begin
                o_res.status = STAT_WRONG;
            end else if (i_st.rnd >= i_rounds) begin
                do_rel = 1'b1;
            end else if (i_flags[own_bit] == i_st.sense) begin
                if (r_inc >= i_rounds) begin
                    do_rel = 1'b1;
                end else begin
                    o_thr_wr.en       = 1'b1;
                    o_thr_wr.data.rnd = r_inc;
                    o_res.rnd         = r_inc;
                    r_sig             = r_inc;
                    signal            = 1'b1;
                end
            end
        end

        if (do_rel) begin
            o_thr_wr.en   = 1'b1;
            o_thr_wr.data = rel_st;
            o_res.status  = STAT_REL;
            o_res.rnd     = '0;
        end
    end

    always_comb begin
        o_flag_wr.en      = signal && (partner < (CNT_W+1)'(i_n_eff));
        o_flag_wr.addr    = partner[THR_W-1:0];
        o_flag_wr.bit_idx = i_st.parity ? BIT_W'(MAX_ROUNDS) + BIT_W'(r_sig) : BIT_W'(r_sig);
        o_flag_wr.value   = i_st.sense;
    end

endmodule

// ===== bench/tb_dissemination_barrier_unit.sv =====
module tb_dissemination_barrier_unit;
    import dbu_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STUCK_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int NUM_PHASES      = 14;
    localparam int HOLD_OFF_PHASE  = 3;
    localparam int PAUSE_PHASE     = 6;

    // Thread-count register value per random phase; a negative entry picks one at random.
    // Zero, one, the full 64 and the saturating 127 are all in the list.
    localparam int PHASE_COUNT [NUM_PHASES] = '{2, 3, 5, 64, 8, 127, 17, 1, 33, 0, 4, 13, -1, -1};
    localparam int PHASE_ITEMS [NUM_PHASES] =
        '{120, 120, 120, 500, 120, 150, 150, 60, 200, 40, 120, 150, 150, 50};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic                i_op          = OP_ARRIVE;
    logic [THR_W-1:0]    i_thread      = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [RND_W-1:0]    o_round;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_num_threads = CNT_W'(MAX_THREADS);

    bit hold_off_req   = 1'b0;
    int stuck_cycles   = 0;
    int settings_used  = 0;

    dissemination_barrier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_thread      (i_thread),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_round       (o_round),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_num_threads (i_num_threads)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Shadow copy of the barrier: per-thread flags, sense, parity, round and
    // in-barrier mark, plus the queue of results still owed by the block.
    class barrier_scoreboard;
        logic [CNT_W-1:0]  thread_count;
        logic [FLAG_W-1:0] flags   [MAX_THREADS];
        logic              sense   [MAX_THREADS];
        logic              parity  [MAX_THREADS];
        logic [RND_W-1:0]  rnd_ctr [MAX_THREADS];
        logic              entered [MAX_THREADS];
        t_result           awaited [$];
        int requests, mismatches, releases, waits, wrong_ops, out_of_range;

        function new();
            restart(CNT_W'(MAX_THREADS));
        endfunction

        // A register write re-initialises the whole barrier, as reset does.
        function void restart(logic [CNT_W-1:0] count);
            thread_count = count;
            for (int t = 0; t < MAX_THREADS; t++) begin
                flags[t]   = '0;
                sense[t]   = 1'b1;
                parity[t]  = 1'b0;
                rnd_ctr[t] = '0;
                entered[t] = 1'b0;
            end
        endfunction

        // Zero means one thread; anything past the array saturates.
        function int active_threads();
            int n;
            n = thread_count;
            if (n == 0) n = 1;
            if (n > MAX_THREADS) n = MAX_THREADS;
            return n;
        endfunction

        function int round_count();
            int n, r;
            n = active_threads();
            r = 0;
            while (r < MAX_ROUNDS && (1 << r) < n) r++;
            return r;
        endfunction

        function bit is_entered(logic [THR_W-1:0] thr);
            return entered[thr];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Write own sense into the partner's flag for the current parity and round.
        function void signal_partner(int t);
            int n, r, partner, b;
            n = active_threads();
            r = rnd_ctr[t];
            partner = t + (1 << r);
            if (partner >= n) partner -= n;
            b = (parity[t] ? MAX_ROUNDS : 0) + r;
            flags[partner][b] = sense[t];
        endfunction

        // Sense flips only on leaving a parity-1 episode.
        function void release_thread(int t);
            if (parity[t]) sense[t] = ~sense[t];
            parity[t]  = ~parity[t];
            rnd_ctr[t] = '0;
            entered[t] = 1'b0;
        endfunction

        function void note_request(logic op, logic [THR_W-1:0] thr);
            int      n, rounds, t, r, b;
            t_result want;
            n      = active_threads();
            rounds = round_count();
            t      = thr;
            requests++;
            want.status = STAT_WAIT;
            want.rnd    = '0;
            if (t >= n) begin
                want.status = STAT_RANGE;
            end else begin
                if (op == OP_ARRIVE) begin
                    if (entered[t]) begin
                        want.status = STAT_WRONG;
                    end else if (rounds == 0) begin
                        release_thread(t);
                        want.status = STAT_REL;
                    end else begin
                        entered[t] = 1'b1;
                        rnd_ctr[t] = '0;
                        signal_partner(t);
                    end
                end else if (!entered[t]) begin
                    want.status = STAT_WRONG;
                end else begin
                    r = rnd_ctr[t];
                    if (r >= rounds) begin
                        release_thread(t);
                        want.status = STAT_REL;
                    end else begin
                        b = (parity[t] ? MAX_ROUNDS : 0) + r;
                        if (flags[t][b] == sense[t]) begin
                            r++;
                            if (r >= rounds) begin
                                release_thread(t);
                                want.status = STAT_REL;
                            end else begin
                                rnd_ctr[t] = RND_W'(r);
                                signal_partner(t);
                            end
                        end
                    end
                end
                want.rnd = rnd_ctr[t];
            end
            case (want.status)
                STAT_WAIT:  waits++;
                STAT_REL:   releases++;
                STAT_WRONG: wrong_ops++;
                default:    out_of_range++;
            endcase
            awaited.push_back(want);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [RND_W-1:0] rnd);
            t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d round %0d with nothing outstanding",
                             status, rnd);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status || rnd !== want.rnd) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: status exp %0d got %0d, round exp %0d got %0d",
                             want.status, status, want.rnd, rnd);
            end
        endfunction
    endclass

    barrier_scoreboard sb = new();

    // Compare every result taken from the block with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_status, o_round);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: long clear runs, short and occasional long stalls, and one
    // deliberate hold-off so the block backs up and stalls its request input.
    initial begin : result_side
        int span;
        int stall_len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else if ($urandom_range(0, 3) == 0) begin
                span = $urandom_range(20, 80);
                repeat (span) begin
                    i_stall <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 3);
                repeat (stall_len) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                span = $urandom_range(1, 8);
                repeat (span) begin
                    i_stall <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
    end

    int burst_left = 0;

    // Sender gap before the next request: bursts with none, mostly short, a few long.
    function automatic int pick_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until the block takes it; predict on acceptance.
    // Called at a rising edge; keep valid high across back-to-back requests.
    task automatic issue(input logic op, input logic [THR_W-1:0] thr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_thread <= thr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(op, thr);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the thread count only with the block idle; the write also clears the barrier.
    task automatic write_thread_count(input logic [CNT_W-1:0] count);
        drain_results();
        i_cfg_valid   <= 1'b1;
        i_num_threads <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.restart(count);
        settings_used++;
    endtask

    initial begin : stimulus
        int               phase;
        int               k;
        int               act;
        int               cursor;
        int               thr_i;
        int               pick;
        logic             op;
        logic [THR_W-1:0] thr;
        logic [CNT_W-1:0] count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset count of 64: poll while outside, top thread arrives twice, early poll.
        issue(OP_POLL,   THR_W'(0));
        issue(OP_ARRIVE, THR_W'(MAX_THREADS - 1));
        issue(OP_ARRIVE, THR_W'(MAX_THREADS - 1));
        issue(OP_POLL,   THR_W'(MAX_THREADS - 1));
        issue(OP_ARRIVE, THR_W'(0));

        // Count zero acts as a single thread: arrive releases at once, others out of range.
        write_thread_count(CNT_W'(0));
        issue(OP_ARRIVE, THR_W'(0));
        issue(OP_ARRIVE, THR_W'(0));
        issue(OP_POLL,   THR_W'(0));
        issue(OP_POLL,   THR_W'(MAX_THREADS - 1));
        issue(OP_ARRIVE, THR_W'(1));

        // All-ones count saturates to the full array.
        write_thread_count({CNT_W{1'b1}});
        issue(OP_ARRIVE, THR_W'(MAX_THREADS - 1));
        issue(OP_POLL,   THR_W'(MAX_THREADS - 1));

        // Two threads through three episodes, crossing both parities and a sense flip.
        write_thread_count(CNT_W'(2));
        issue(OP_ARRIVE, THR_W'(0));
        issue(OP_ARRIVE, THR_W'(1));
        issue(OP_POLL,   THR_W'(0));
        issue(OP_POLL,   THR_W'(1));
        issue(OP_ARRIVE, THR_W'(1));
        issue(OP_ARRIVE, THR_W'(0));
        issue(OP_POLL,   THR_W'(1));
        issue(OP_POLL,   THR_W'(0));
        issue(OP_ARRIVE, THR_W'(0));
        issue(OP_POLL,   THR_W'(0));
        issue(OP_ARRIVE, THR_W'(1));
        issue(OP_POLL,   THR_W'(0));

        // Random phases: mostly well-formed sweeps (arrive if outside, poll if inside),
        // the rest random op on any thread index.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            count = (PHASE_COUNT[phase] < 0) ? CNT_W'($urandom_range(1, MAX_THREADS))
                                             : CNT_W'(PHASE_COUNT[phase]);
            write_thread_count(count);
            if (phase == HOLD_OFF_PHASE) hold_off_req = 1'b1;
            act    = sb.active_threads();
            cursor = $urandom_range(0, act - 1);
            for (k = 0; k < PHASE_ITEMS[phase]; k++) begin
                if (phase == PAUSE_PHASE && k == PHASE_ITEMS[phase] / 2) drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    thr_i  = (cursor + $urandom_range(0, 3)) % act;
                    cursor = thr_i + 1;
                    thr    = THR_W'(thr_i);
                    op     = sb.is_entered(thr) ? OP_POLL : OP_ARRIVE;
                end else begin
                    op  = 1'($urandom_range(0, 1));
                    thr = THR_W'($urandom_range(0, MAX_THREADS - 1));
                end
                issue(op, thr);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over %0d thread-count settings (0, 1, 64 and 127 among them).",
                 sb.requests, settings_used);
        $display("Outcomes: %0d released, %0d waiting, %0d wrong op, %0d out of range; %0d mismatches.",
                 sb.releases, sb.waits, sb.wrong_ops, sb.out_of_range, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== dissemination_barrier_unit.f =====
src/dbu_pkg.sv
src/dbu_state_mem.sv
src/dbu_flag_mem.sv
src/dbu_step.sv
src/dissemination_barrier_unit.sv
bench/tb_dissemination_barrier_unit.sv
